/* hdl/pits_pkg.sv */
`timescale 1ns / 1ps

package pits_pkg;

  // field and register widths
  localparam int LAMBDA_W  = 15;   // Q4.11
  localparam int Q_W       = 33;   // Q0.32 with room for 1.0
  localparam int CDF_W     = 34;   // cdf accumulator
  localparam int U_W       = 17;   // uniform sample, 65536 = 1.0
  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_COUNT_DEF = 255;

  // register reset values
  localparam logic [LAMBDA_W-1:0] LAMBDA_RST = 15'd2048;
  localparam logic [Q_W-1:0]      EXPNL_RST  = 33'd1580030169;
  localparam logic [Q_W-1:0]      CUTOFF_RST = 33'd4290672329;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPNL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 2'd2;

endpackage

/* hdl/pits_recip_rom.sv */
`timescale 1ns / 1ps

// 1/x reciprocal table, Q0.32, rounded: floor((2^32 + floor(x/2)) / x).
// Built at elaboration by long division; read data registered.
module pits_recip_rom #(
  parameter int MAX_COUNT = pits_pkg::MAX_COUNT_DEF
) (
  input  logic                            clk,
  input  logic [$clog2(MAX_COUNT+1)-1:0]  addr,
  output logic [pits_pkg::Q_W-1:0]        recip
);
  import pits_pkg::*;

  typedef logic [Q_W-1:0] recip_tab_t [0:MAX_COUNT];

  function automatic recip_tab_t build_tab();
    recip_tab_t   tab;
    logic [33:0]  num;
    logic [34:0]  rem;
    logic [33:0]  quo;
    logic [34:0]  den;
    tab[0] = '0;
    for (int x = 1; x <= MAX_COUNT; x++) begin
      den = 35'(x);
      num = 34'(64'd4294967296 + 64'(x >> 1));
      rem = '0;
      quo = '0;
      for (int i = 33; i >= 0; i--) begin
        rem = {rem[33:0], num[i]};
        if (rem >= den) begin
          rem    = rem - den;
          quo[i] = 1'b1;
        end
      end
      tab[x] = quo[Q_W-1:0];
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = build_tab();

  logic [Q_W-1:0] recip_r;

  always_ff @(posedge clk) begin
    recip_r <= RECIP_TAB[addr];
  end

  assign recip = recip_r;

endmodule

/* hdl/poisson_inverse_transform_sampler.sv */
`timescale 1ns / 1ps

// Poisson inverse-transform sampler.
// Input stream (in_*): one beat carries a uniform sample u (65536 = 1.0).
// Output stream (out_*): one beat per input beat with the Poisson count in
// out_tdata and the saturation flag in out_tuser.
// Config channel (cfg_*): index 0 lambda (Q4.11), 1 exp(-lambda) (Q0.32),
// 2 cdf cutoff (Q0.32); writes are always taken, but the user must write
// only while the block idles; the block itself does not enforce it.
// Starting at pmf = cdf = exp(-lambda), each further term runs these steps
// in order on one shared 37x17 multiplier: pmf*lambda, round, a*recip_hi,
// a*recip_lo, recombine and saturate pmf, accumulate cdf, compare. A sample
// needing n extra terms goes through them n times; n is about lambda for
// typical u, at most MAX_COUNT-1.
// The input is not ready while a sample is in flight. The result sits in an
// output register, so the next sample is accepted while it waits; if the
// receiver still stalls when that sample finishes, it holds in the final
// state until the output register frees up.
// Reset (rst_n low, synchronous) returns the registers to lambda = 1.0,
// exp(-1) and 0.999, empties the output and idles the sequencer.
module poisson_inverse_transform_sampler #(
  parameter int MAX_COUNT = pits_pkg::MAX_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,   // [16:0] uniform_sample
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [7:0] count
  output logic [0:0]                        out_tuser,  // [0] saturated
  // config writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pits_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pits_pkg::Q_W-1:0]          cfg_data
);
  import pits_pkg::*;

  localparam int XW      = $clog2(MAX_COUNT + 1);
  localparam int MA_W    = 37;               // multiplier A operand
  localparam int MB_W    = 17;               // multiplier B operand
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam logic [XW:0] MAXC = (XW + 1)'(MAX_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MUL1, S_AREG, S_MUL2, S_MUL3, S_PMF, S_CDF, S_FIN
  } state_t;

  // config registers
  logic [LAMBDA_W-1:0] lambda_r;
  logic [Q_W-1:0]      expnl_r;
  logic [Q_W-1:0]      cutoff_r;

  // walk state
  state_t              state_r, state_nxt;
  logic [XW-1:0]       x_r, x_nxt;
  logic                sat_r, sat_nxt;
  logic [Q_W-1:0]      pmf_r, pmf_nxt;
  logic [CDF_W-1:0]    cdf_r, cdf_nxt;
  logic [Q_W-1:0]      u_r, u_nxt;
  logic [MA_W-1:0]     a_r, a_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [PROD_W-1:0]   hi_r, hi_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                out_sat_r, out_sat_nxt;

  // shared multiplier
  logic [MA_W-1:0]     mul_a;
  logic [MB_W-1:0]     mul_b;
  logic [PROD_W-1:0]   mul_p;

  logic [Q_W-1:0]      recip;
  logic [ACC_W-1:0]    lo_rnd;
  logic [ACC_W-1:0]    p_full;
  logic [CDF_W:0]      cdf_sum;
  logic                out_free;
  logic                x_at_limit;

  pits_recip_rom #(.MAX_COUNT(MAX_COUNT)) u_rom (
    .clk   (clk),
    .addr  (x_r),
    .recip (recip)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_count_r;
  assign out_tuser  = out_sat_r;
  assign out_free   = !out_valid_r || out_tready;

  // operand select for the single multiplier
  always_comb begin
    case (state_r)
      S_MUL1: begin
        mul_a = MA_W'(pmf_r);
        mul_b = MB_W'(lambda_r);
      end
      S_MUL2: begin
        mul_a = a_r;
        mul_b = recip[Q_W-1:16];
      end
      S_MUL3: begin
        mul_a = a_r;
        mul_b = {1'b0, recip[15:0]};
      end
      default: begin
        mul_a = a_r;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // pmf = (hi + ((lo + 2^31) >> 16)) >> 16, lo held in prod_r
  assign lo_rnd  = (ACC_W'(prod_r) + (ACC_W'(1) << 31)) >> 16;
  assign p_full  = (ACC_W'(hi_r) + lo_rnd) >> 16;
  assign cdf_sum = (CDF_W + 1)'(cdf_r) + (CDF_W + 1)'(pmf_r);

  assign x_at_limit = ((XW + 1)'(x_r) + (XW + 1)'(1)) >= MAXC;

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    sat_nxt       = sat_r;
    pmf_nxt       = pmf_r;
    cdf_nxt       = cdf_r;
    u_nxt         = u_r;
    a_nxt         = a_r;
    prod_nxt      = prod_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_count_nxt = out_count_r;
    out_sat_nxt   = out_sat_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          u_nxt     = {in_tdata[U_W-1:0], 16'b0};
          pmf_nxt   = expnl_r;
          cdf_nxt   = CDF_W'(expnl_r);
          x_nxt     = '0;
          sat_nxt   = 1'b0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (cdf_r >= CDF_W'(u_r)) begin
          state_nxt = S_FIN;
        end else if (cdf_r >= CDF_W'(cutoff_r)) begin
          // table ends here: one past the last term
          x_nxt     = x_r + 1'b1;
          state_nxt = S_FIN;
        end else if (x_at_limit) begin
          x_nxt     = XW'(MAX_COUNT);
          sat_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          x_nxt     = x_r + 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        prod_nxt  = mul_p;
        state_nxt = S_AREG;
      end
      S_AREG: begin
        a_nxt     = MA_W'((prod_r + PROD_W'(1024)) >> 11);
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        prod_nxt  = mul_p;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        hi_nxt    = prod_r;
        prod_nxt  = mul_p;
        state_nxt = S_PMF;
      end
      S_PMF: begin
        pmf_nxt   = (|p_full[ACC_W-1:Q_W]) ? '1 : p_full[Q_W-1:0];
        state_nxt = S_CDF;
      end
      S_CDF: begin
        cdf_nxt   = cdf_sum[CDF_W] ? '1 : cdf_sum[CDF_W-1:0];
        state_nxt = S_CHECK;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = COUNT_W'(x_r);
          out_sat_nxt   = sat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lambda_r    <= LAMBDA_RST;
      expnl_r     <= EXPNL_RST;
      cutoff_r    <= CUTOFF_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LAMBDA: lambda_r <= cfg_data[LAMBDA_W-1:0];
          CFG_EXPNL:  expnl_r  <= cfg_data;
          CFG_CUTOFF: cutoff_r <= cfg_data;
          default:    ;
        endcase
      end
    end
    x_r         <= x_nxt;
    sat_r       <= sat_nxt;
    pmf_r       <= pmf_nxt;
    cdf_r       <= cdf_nxt;
    u_r         <= u_nxt;
    a_r         <= a_nxt;
    prod_r      <= prod_nxt;
    hi_r        <= hi_nxt;
    out_count_r <= out_count_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  // one sample in flight: an accepted beat closes the input
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a sample is in flight");

  // walk index stays within the table
  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ((XW + 1)'(x_r) <= MAXC))
    else $error("walk index past MAX_COUNT");

  // cdf only grows across an accumulate step
  a_cdf_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CDF) |=> (cdf_r >= $past(cdf_r)))
    else $error("cdf decreased");

  // a saturated result always carries MAX_COUNT
  a_sat_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> (out_count_r == COUNT_W'(MAX_COUNT)))
    else $error("saturated result with wrong count");

endmodule
